### sv/sali_pkg.sv
// Shared constants, types and state encodings for the smoothed converter level indicator.
// Used by the channel interfaces, the averaging core, the top level and the checker.
// No dependencies.
package sali_pkg;

   // Sample and arithmetic widths
   localparam int SAMPLE_BITS = 12;
   localparam int WEIGHT_W    = 8;
   localparam int SUM_W       = WEIGHT_W + 1;
   localparam int ACC_W       = SAMPLE_BITS + SUM_W;
   localparam int CNT_W       = $clog2(SAMPLE_BITS);
   localparam int THR_W       = 12;
   localparam int PERIOD_W    = 16;
   localparam int LEVEL_W     = 2;
   localparam int CMP_W       = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

   // Last step index of each pass on the shared unit, counted down to zero
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(WEIGHT_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(SAMPLE_BITS - 1);

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_HIGH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_MID  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_OLD     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_NEW     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_PERIOD   = 3'd5;

   // Register reset values
   localparam logic [THR_W-1:0]    THRESHOLD_HIGH_RST = 12'd3096;
   localparam logic [THR_W-1:0]    THRESHOLD_MID_RST  = 12'd2048;
   localparam logic [THR_W-1:0]    THRESHOLD_LOW_RST  = 12'd1024;
   localparam logic [WEIGHT_W-1:0] WEIGHT_OLD_RST     = 8'd10;
   localparam logic [WEIGHT_W-1:0] WEIGHT_NEW_RST     = 8'd1;
   localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST   = 16'd50;

   // Indicator level codes
   typedef enum logic [LEVEL_W-1:0] {
      LEVEL_OFF   = 2'd0,
      LEVEL_BLUE  = 2'd1,
      LEVEL_GREEN = 2'd2,
      LEVEL_RED   = 2'd3
   } level_type;

   // Top level sequencer
   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_BUSY,
      TOP_OUT
   } top_state_type;

   // Averaging core sequencer
   typedef enum logic [2:0] {
      CORE_IDLE,
      CORE_MUL_OLD,
      CORE_MUL_NEW,
      CORE_DIV,
      CORE_DONE
   } core_state_type;

   // Top level to core: start strobe and operands
   typedef struct packed {
      logic                   start;
      logic [SAMPLE_BITS-1:0] sample;
      logic [SAMPLE_BITS-1:0] old_value;
      logic [WEIGHT_W-1:0]    weight_old;
      logic [WEIGHT_W-1:0]    weight_new;
   } core_req_type;

   // Core to top level: status and quotient
   typedef struct packed {
      logic                   busy;
      logic                   done;
      logic [SAMPLE_BITS-1:0] result;
   } core_stat_type;

endpackage

### sv/sali_req_if.sv
// Input channel of the level indicator: one converter sample per item.
// Depends on sali_pkg for the sample width.
interface sali_req_if;
   logic                            valid;
   logic                            ready;
   logic [sali_pkg::SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

### sv/sali_rsp_if.sv
// Result channel of the level indicator: smoothed value, level and blink toggles.
// Depends on sali_pkg for the field widths.
interface sali_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sali_pkg::SAMPLE_BITS-1:0] smoothed;
   logic [sali_pkg::LEVEL_W-1:0]     level;
   logic                            fast_toggle;
   logic                            slow_toggle;

   modport source (output valid, output smoothed, output level, output fast_toggle,
                   output slow_toggle, input ready);
   modport sink   (input valid, input smoothed, input level, input fast_toggle,
                   input slow_toggle, output ready);
endinterface

### sv/sali_core.sv
// Weighted average core: shift-add products and restoring division on one shared adder.
// Depends on sali_pkg.
module sali_core (
   input  logic                    clock,
   input  logic                    reset,
   input  sali_pkg::core_req_type  core_req,
   output sali_pkg::core_stat_type core_stat
);
   import sali_pkg::*;

   core_state_type         state_ff, state_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [ACC_W-1:0]       mcand_ff, mcand_in;
   logic [WEIGHT_W-1:0]    mult_ff, mult_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [WEIGHT_W-1:0]    wnew_ff, wnew_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   logic [SUM_W-1:0]       start_sum;
   logic [SUM_W:0]         trial;
   logic [ACC_W:0]         alu_a, alu_b, alu_res;
   logic                   alu_sub;
   logic                   borrow;

   // Partial remainder with the next dividend bit shifted in
   assign trial = acc_ff[ACC_W-1:SAMPLE_BITS-1];
   assign start_sum = {1'b0, core_req.weight_old} + {1'b0, core_req.weight_new};

   // Shared adder: accumulate in the product steps, trial subtract in the divide steps
   always_comb begin
      if (state_ff == CORE_DIV) begin
         alu_a   = {{(ACC_W-SUM_W){1'b0}}, trial};
         alu_b   = {{(ACC_W+1-SUM_W){1'b0}}, sum_ff};
         alu_sub = 1'b1;
      end else begin
         alu_a   = {1'b0, acc_ff};
         alu_b   = {1'b0, mcand_ff};
         alu_sub = 1'b0;
      end
      alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
   end

   assign borrow = alu_res[ACC_W];

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mult_in   = mult_ff;
      sample_in = sample_ff;
      wnew_in   = wnew_ff;
      sum_in    = sum_ff;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         CORE_IDLE: begin
            if (core_req.start) begin
               sample_in = core_req.sample;
               wnew_in   = core_req.weight_new;
               sum_in    = start_sum;
               mcand_in  = ACC_W'(core_req.old_value);
               mult_in   = core_req.weight_old;
               cnt_in    = MUL_LAST;
               // Both weights zero: hold the old value, skip the arithmetic
               if (start_sum == '0) begin
                  acc_in   = ACC_W'(core_req.old_value);
                  state_in = CORE_DONE;
               end else begin
                  acc_in   = '0;
                  state_in = CORE_MUL_OLD;
               end
            end
         end
         CORE_MUL_OLD, CORE_MUL_NEW: begin
            if (mult_ff[0]) begin
               acc_in = alu_res[ACC_W-1:0];
            end
            mcand_in = mcand_ff << 1;
            mult_in  = mult_ff >> 1;
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (state_ff == CORE_MUL_OLD) begin
                  mcand_in = ACC_W'(sample_ff);
                  mult_in  = wnew_ff;
                  cnt_in   = MUL_LAST;
                  state_in = CORE_MUL_NEW;
               end else begin
                  cnt_in   = DIV_LAST;
                  state_in = CORE_DIV;
               end
            end
         end
         CORE_DIV: begin
            // Keep the remainder on a borrow, else take the difference; shift in quotient bit
            acc_in = {(borrow ? trial[SUM_W-1:0] : alu_res[SUM_W-1:0]),
                      acc_ff[SAMPLE_BITS-2:0], ~borrow};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = CORE_DONE;
            end
         end
         CORE_DONE: begin
            state_in = CORE_IDLE;
         end
         default: begin
            state_in = CORE_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mult_ff   <= mult_in;
      sample_ff <= sample_in;
      wnew_ff   <= wnew_in;
      sum_ff    <= sum_in;
      cnt_ff    <= cnt_in;
   end

   assign core_stat.busy   = (state_ff != CORE_IDLE);
   assign core_stat.done   = (state_ff == CORE_DONE);
   assign core_stat.result = acc_ff[SAMPLE_BITS-1:0];

endmodule

### sv/smoothed_adc_level_indicator.sv
// Top level of the smoothed converter level indicator: registers, blink counter, output.
// Depends on sali_pkg, sali_req_if, sali_rsp_if and sali_core.
//
// Usage:
//   req_chan carries one converter sample per item (valid/ready). Each item gives
//   exactly one item on rsp_chan: the new smoothed value, its level code (off, blue,
//   green, red) and the fast and slow blink toggles for this tick.
//   csr_we/csr_index/csr_wdata write the thresholds, weights and blink period; writes
//   to unused indexes are dropped. Write them only while the block is idle.
//   Each item runs 8 + 8 shift-add steps for the two products, 12 restoring divide
//   steps and a finish step before rsp valid; with both weights zero only the finish
//   step runs. All steps run on one shared adder in sali_core.
//   One item at a time: req ready is high only while idle, so no new sample is
//   accepted until the result of the last one has been taken.
//   When the receiver stalls, the result holds in the output register and no new
//   sample is accepted until it is taken.
//   Reset (synchronous, active high) restores the register defaults and clears the
//   smoothed value, the tick phase and the wrap parity.
module smoothed_adc_level_indicator (
   input  logic                               clock,
   input  logic                               reset,
   sali_req_if.sink                           req_chan,
   sali_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [sali_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sali_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sali_pkg::*;

   top_state_type          state_ff, state_in;
   logic [THR_W-1:0]       thr_high_ff, thr_mid_ff, thr_low_ff;
   logic [WEIGHT_W-1:0]    weight_old_ff, weight_new_ff;
   logic [PERIOD_W-1:0]    period_ff;
   logic [SAMPLE_BITS-1:0] smooth_ff;
   logic [PERIOD_W-1:0]    phase_ff, phase_in;
   logic                   parity_ff, parity_in;
   logic [SAMPLE_BITS-1:0] out_smoothed_ff;
   level_type              out_level_ff, level_in;
   logic                   out_fast_ff, out_slow_ff;

   logic                   req_fire;
   logic [PERIOD_W:0]      phase_next;
   logic                   wrap;
   logic [CMP_W-1:0]       cmp_value;
   core_req_type           core_req;
   core_stat_type          core_stat;

   assign req_fire = req_chan.valid && req_chan.ready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_high_ff   <= THRESHOLD_HIGH_RST;
         thr_mid_ff    <= THRESHOLD_MID_RST;
         thr_low_ff    <= THRESHOLD_LOW_RST;
         weight_old_ff <= WEIGHT_OLD_RST;
         weight_new_ff <= WEIGHT_NEW_RST;
         period_ff     <= BLINK_PERIOD_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_THRESHOLD_HIGH: thr_high_ff   <= csr_wdata[THR_W-1:0];
            CSR_THRESHOLD_MID:  thr_mid_ff    <= csr_wdata[THR_W-1:0];
            CSR_THRESHOLD_LOW:  thr_low_ff    <= csr_wdata[THR_W-1:0];
            CSR_WEIGHT_OLD:     weight_old_ff <= csr_wdata[WEIGHT_W-1:0];
            CSR_WEIGHT_NEW:     weight_new_ff <= csr_wdata[WEIGHT_W-1:0];
            CSR_BLINK_PERIOD:   period_ff     <= csr_wdata[PERIOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Blink counter: wrap when the advanced phase reaches the period
   assign phase_next = {1'b0, phase_ff} + 1'b1;
   assign wrap       = (phase_next >= {1'b0, period_ff});
   assign phase_in   = wrap ? '0 : phase_next[PERIOD_W-1:0];
   assign parity_in  = parity_ff ^ wrap;

   // Classify the new smoothed value, red first
   assign cmp_value = CMP_W'(core_stat.result);
   always_comb begin
      priority if (cmp_value >= CMP_W'(thr_high_ff)) begin
         level_in = LEVEL_RED;
      end else if (cmp_value >= CMP_W'(thr_mid_ff)) begin
         level_in = LEVEL_GREEN;
      end else if (cmp_value >= CMP_W'(thr_low_ff)) begin
         level_in = LEVEL_BLUE;
      end else begin
         level_in = LEVEL_OFF;
      end
   end

   // Start the core on each accepted item
   assign core_req.start      = req_fire;
   assign core_req.sample     = req_chan.sample;
   assign core_req.old_value  = smooth_ff;
   assign core_req.weight_old = weight_old_ff;
   assign core_req.weight_new = weight_new_ff;

   sali_core u_core (
      .clock     (clock),
      .reset     (reset),
      .core_req  (core_req),
      .core_stat (core_stat)
   );

   // Sequencer: idle, wait for the core, present the result
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TOP_IDLE: begin
            if (req_fire) begin
               state_in = TOP_BUSY;
            end
         end
         TOP_BUSY: begin
            if (core_stat.done) begin
               state_in = TOP_OUT;
            end
         end
         TOP_OUT: begin
            if (rsp_chan.ready) begin
               state_in = TOP_IDLE;
            end
         end
         default: begin
            state_in = TOP_IDLE;
         end
      endcase
   end

   // Control and tick state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= TOP_IDLE;
         smooth_ff <= '0;
         phase_ff  <= '0;
         parity_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            phase_ff  <= phase_in;
            parity_ff <= parity_in;
         end
         if (core_stat.done && state_ff == TOP_BUSY) begin
            smooth_ff <= core_stat.result;
         end
      end
   end

   // Output register: toggles at accept, value and level when the core finishes
   always_ff @(posedge clock) begin
      if (req_fire) begin
         out_fast_ff <= wrap;
         out_slow_ff <= wrap & parity_ff;
      end
      if (core_stat.done && state_ff == TOP_BUSY) begin
         out_smoothed_ff <= core_stat.result;
         out_level_ff    <= level_in;
      end
   end

   assign req_chan.ready       = (state_ff == TOP_IDLE) && !core_stat.busy;
   assign rsp_chan.valid       = (state_ff == TOP_OUT);
   assign rsp_chan.smoothed    = out_smoothed_ff;
   assign rsp_chan.level       = out_level_ff;
   assign rsp_chan.fast_toggle = out_fast_ff;
   assign rsp_chan.slow_toggle = out_slow_ff;

endmodule

### sv/sali_checker.sv
// Port-level checks for the smoothed converter level indicator, bound to the top level.
// Depends on sali_pkg and smoothed_adc_level_indicator.
module sali_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [sali_pkg::SAMPLE_BITS-1:0] rsp_smoothed,
   input logic [sali_pkg::LEVEL_W-1:0]     rsp_level,
   input logic                             rsp_fast_toggle,
   input logic                             rsp_slow_toggle
);
   import sali_pkg::*;

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_smoothed) && $stable(rsp_level)
         && $stable(rsp_fast_toggle) && $stable(rsp_slow_toggle))
      else $error("result changed while stalled");

   // One item at a time: no new sample right after one is accepted
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample accepted while busy");

   // One result per item: none right after a result is taken
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("result repeated");

   // Ready for a sample only when no result is pending
   a_ready_no_result: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("ready while a result is pending");

   // Slow toggle only on a wrap
   a_slow_on_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_slow_toggle |-> rsp_fast_toggle)
      else $error("slow toggle without fast toggle");

endmodule

bind smoothed_adc_level_indicator sali_checker u_sali_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_smoothed    (rsp_chan.smoothed),
   .rsp_level       (rsp_chan.level),
   .rsp_fast_toggle (rsp_chan.fast_toggle),
   .rsp_slow_toggle (rsp_chan.slow_toggle)
);

### bench/smoothed_adc_level_indicator_tb.sv
// Self-checking testbench for the smoothed converter level indicator.
// Depends on sali_pkg, sali_req_if, sali_rsp_if and the top level smoothed_adc_level_indicator.
// An in-bench predictor tracks the smoothed value, level, blink phase and parity per sample.
`timescale 1ns / 100ps

module smoothed_adc_level_indicator_tb;
   import sali_pkg::*;

   localparam int LIMIT_CYCLES = 400_000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] smoothed;
      level_type              level;
      logic                   fast_toggle;
      logic                   slow_toggle;
   } indicator_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sali_req_if req_chan ();
   sali_rsp_if rsp_chan ();

   smoothed_adc_level_indicator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor copy of the registers and state
   logic [THR_W-1:0]       cfg_thr_high;
   logic [THR_W-1:0]       cfg_thr_mid;
   logic [THR_W-1:0]       cfg_thr_low;
   logic [WEIGHT_W-1:0]    cfg_weight_old;
   logic [WEIGHT_W-1:0]    cfg_weight_new;
   logic [PERIOD_W-1:0]    cfg_period;
   logic [SAMPLE_BITS-1:0] avg_value;
   logic [PERIOD_W-1:0]    blink_phase;
   logic                   blink_parity;

   indicator_result_type pending_results[$];

   int  samples_sent    = 0;
   int  results_checked = 0;
   int  csr_writes      = 0;
   int  wraps_seen      = 0;
   int  error_count     = 0;
   int  cycle_count     = 0;
   bit  req_held        = 1'b0;
   bit  req_gaps_on     = 1'b0;
   bit  rsp_stalls_on   = 1'b0;
   int  rsp_hold_cycles = 0;

   // Clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("smoothed_adc_level_indicator_tb: done, errors");
         $finish;
      end
   end

   // Predictor: register write
   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_THRESHOLD_HIGH: cfg_thr_high   = data[THR_W-1:0];
         CSR_THRESHOLD_MID:  cfg_thr_mid    = data[THR_W-1:0];
         CSR_THRESHOLD_LOW:  cfg_thr_low    = data[THR_W-1:0];
         CSR_WEIGHT_OLD:     cfg_weight_old = data[WEIGHT_W-1:0];
         CSR_WEIGHT_NEW:     cfg_weight_new = data[WEIGHT_W-1:0];
         CSR_BLINK_PERIOD:   cfg_period     = data[PERIOD_W-1:0];
         default: ;
      endcase
   endfunction

   // Predictor: advance smoothing and blink state by one sample, return the result
   function automatic indicator_result_type advance_indicator(
         input logic [SAMPLE_BITS-1:0] raw);
      indicator_result_type res;
      logic [SUM_W-1:0]     wsum;
      logic [ACC_W-1:0]     num;
      logic [ACC_W-1:0]     quot;
      logic [PERIOD_W:0]    phase_next;
      wsum = SUM_W'(cfg_weight_old) + SUM_W'(cfg_weight_new);
      // hold the value when both weights are zero
      if (wsum != '0) begin
         num  = ACC_W'(cfg_weight_old) * ACC_W'(avg_value) + ACC_W'(cfg_weight_new) * ACC_W'(raw);
         quot = num / ACC_W'(wsum);
         avg_value = quot[SAMPLE_BITS-1:0];
      end
      res.fast_toggle = 1'b0;
      res.slow_toggle = 1'b0;
      // wrap when the phase reaches the period; period zero wraps every tick
      phase_next = {1'b0, blink_phase} + 1'b1;
      if (phase_next >= {1'b0, cfg_period}) begin
         blink_phase     = '0;
         res.fast_toggle = 1'b1;
         blink_parity    = ~blink_parity;
         res.slow_toggle = ~blink_parity;
      end else begin
         blink_phase = phase_next[PERIOD_W-1:0];
      end
      res.smoothed = avg_value;
      if (avg_value >= cfg_thr_high)     res.level = LEVEL_RED;
      else if (avg_value >= cfg_thr_mid) res.level = LEVEL_GREEN;
      else if (avg_value >= cfg_thr_low) res.level = LEVEL_BLUE;
      else                               res.level = LEVEL_OFF;
      return res;
   endfunction

   // Result checker
   always @(posedge clock) begin : check_results
      indicator_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $error("result with no item pending: smoothed %0d level %0d",
                   rsp_chan.smoothed, rsp_chan.level);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_chan.smoothed !== want.smoothed) begin
               $error("smoothed: expected %0d, got %0d", want.smoothed, rsp_chan.smoothed);
               error_count++;
            end
            if (rsp_chan.level !== want.level) begin
               $error("level: expected %0d, got %0d", want.level, rsp_chan.level);
               error_count++;
            end
            if (rsp_chan.fast_toggle !== want.fast_toggle) begin
               $error("fast_toggle: expected %0b, got %0b", want.fast_toggle,
                      rsp_chan.fast_toggle);
               error_count++;
            end
            if (rsp_chan.slow_toggle !== want.slow_toggle) begin
               $error("slow_toggle: expected %0b, got %0b", want.slow_toggle,
                      rsp_chan.slow_toggle);
               error_count++;
            end
         end
      end
   end

   // Receiver: random stall bursts, long hold-off on request
   initial begin : drive_rsp_ready
      int n;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_chan.ready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else if (rsp_stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Drop valid if it was left high after the last accepted item
   task automatic req_drop();
      if (req_held) begin
         req_chan.valid <= 1'b0;
         req_held = 1'b0;
      end
   endtask

   // Offer one sample, wait for acceptance, record its expected result
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] raw);
      indicator_result_type res;
      req_chan.valid  <= 1'b1;
      req_chan.sample <= raw;
      req_held = 1'b1;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      res = advance_indicator(raw);
      if (res.fast_toggle) wraps_seen++;
      pending_results.push_back(res);
      samples_sent++;
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         req_drop();
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every result has been taken
   task automatic settle_idle();
      req_drop();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Write one register; csr_we stays high until csr_done
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      apply_csr(idx, data);
      csr_writes++;
   endtask

   task automatic csr_done();
      csr_we <= 1'b0;
   endtask

   task automatic set_weights(input logic [WEIGHT_W-1:0] w_old, input logic [WEIGHT_W-1:0] w_new);
      settle_idle();
      write_csr(CSR_WEIGHT_OLD, CSR_DATA_W'(w_old));
      write_csr(CSR_WEIGHT_NEW, CSR_DATA_W'(w_new));
      csr_done();
   endtask

   task automatic set_thresholds(input logic [THR_W-1:0] hi, input logic [THR_W-1:0] mid,
                                 input logic [THR_W-1:0] lo);
      settle_idle();
      write_csr(CSR_THRESHOLD_HIGH, CSR_DATA_W'(hi));
      write_csr(CSR_THRESHOLD_MID, CSR_DATA_W'(mid));
      write_csr(CSR_THRESHOLD_LOW, CSR_DATA_W'(lo));
      csr_done();
   endtask

   task automatic set_period(input logic [PERIOD_W-1:0] period);
      settle_idle();
      write_csr(CSR_BLINK_PERIOD, period);
      csr_done();
   endtask

   // Random field pickers
   function automatic logic [THR_W-1:0] pick_threshold();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return {THR_W{1'b1}};
         default: return THR_W'($urandom_range(0, 4095));
      endcase
   endfunction

   function automatic logic [PERIOD_W-1:0] pick_period();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return 16'd1;
         2:       return {PERIOD_W{1'b1}};
         3:       return PERIOD_W'($urandom_range(41, 1000));
         default: return PERIOD_W'($urandom_range(2, 40));
      endcase
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      logic [THR_W-1:0] edge_val;
      case ($urandom_range(0, 9))
         0: return '0;
         1: return {SAMPLE_BITS{1'b1}};
         2: begin
            // land near one of the active thresholds
            case ($urandom_range(0, 2))
               0:       edge_val = cfg_thr_high;
               1:       edge_val = cfg_thr_mid;
               default: edge_val = cfg_thr_low;
            endcase
            return SAMPLE_BITS'(edge_val + $urandom_range(0, 6) - 3);
         end
         default: return SAMPLE_BITS'($urandom_range(0, 4095));
      endcase
   endfunction

   // Directed: reset defaults with a few samples
   task automatic test_defaults();
      send_sample('0);
      send_sample(12'd4095);
      send_sample(12'd4095);
   endtask

   // Directed: weight extremes and threshold boundaries
   task automatic test_weight_extremes();
      set_weights(8'd0, 8'd255);
      send_sample(12'd4095);
      send_sample(12'd0);
      send_sample(12'd3096);
      send_sample(12'd3095);
      send_sample(12'd2048);
      send_sample(12'd2047);
      send_sample(12'd1024);
      send_sample(12'd1023);
      set_weights(8'd255, 8'd255);
      send_sample(12'd4095);
      set_weights(8'd255, 8'd1);
      send_sample(12'd0);
   endtask

   // Directed: both weights zero hold the value
   task automatic test_zero_weights();
      set_weights(8'd0, 8'd0);
      send_sample(12'd4095);
      send_sample(12'd0);
   endtask

   // Directed: thresholds out of order and at the top
   task automatic test_threshold_order();
      set_weights(8'd0, 8'd1);
      set_thresholds(12'd0, 12'd4095, 12'd2048);
      send_sample(12'd0);
      set_thresholds(12'd4095, 12'd4095, 12'd4095);
      send_sample(12'd4094);
      send_sample(12'd4095);
   endtask

   // Directed: period zero, one, and lowered below the current phase
   task automatic test_blink_period();
      set_period(16'd0);
      send_sample(12'd100);
      send_sample(12'd200);
      set_period(16'd1);
      send_sample(12'd300);
      set_period(16'd5);
      send_sample(12'd400);
      send_sample(12'd500);
      send_sample(12'd600);
      set_period(16'd2);
      send_sample(12'd700);
   endtask

   // Directed: writes to unused indexes are dropped
   task automatic test_unused_index();
      settle_idle();
      write_csr(CSR_IDX_W'(6), 16'hFFFF);
      write_csr(CSR_IDX_W'(7), 16'h0000);
      csr_done();
      send_sample(12'd2500);
   endtask

   // Long receiver hold-off while the sender keeps offering
   task automatic test_backpressure();
      settle_idle();
      req_gaps_on = 1'b0;
      rsp_hold_cycles = 300;
      repeat (6) send_sample(pick_sample());
   endtask

   // Sender pauses mid-stream until every result has come
   task automatic test_drain_pause();
      repeat (5) send_sample(pick_sample());
      settle_idle();
      repeat (5) send_sample(pick_sample());
   endtask

   // Random settings followed by a stream of random samples
   task automatic test_random_phase(input int n_items, input bit gaps, input bit stalls);
      logic [THR_W-1:0] t0, t1, t2, tmp;
      logic [WEIGHT_W-1:0] w_old, w_new;
      settle_idle();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = stalls;
      t0 = pick_threshold();
      t1 = pick_threshold();
      t2 = pick_threshold();
      // keep thresholds in order most of the time
      if ($urandom_range(0, 3) != 0) begin
         if (t0 < t1) begin tmp = t0; t0 = t1; t1 = tmp; end
         if (t1 < t2) begin tmp = t1; t1 = t2; t2 = tmp; end
         if (t0 < t1) begin tmp = t0; t0 = t1; t1 = tmp; end
      end
      case ($urandom_range(0, 7))
         0:       w_old = '0;
         1:       w_old = 8'd255;
         default: w_old = WEIGHT_W'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 9))
         0:       w_new = '0;
         1:       w_new = 8'd255;
         default: w_new = WEIGHT_W'($urandom_range(1, 255));
      endcase
      if ($urandom_range(0, 3) == 0)
         write_csr(CSR_IDX_W'($urandom_range(6, 7)), CSR_DATA_W'($urandom));
      write_csr(CSR_THRESHOLD_HIGH, {4'($urandom), t0});
      write_csr(CSR_THRESHOLD_MID, {4'($urandom), t1});
      write_csr(CSR_THRESHOLD_LOW, {4'($urandom), t2});
      write_csr(CSR_WEIGHT_OLD, {8'($urandom), w_old});
      write_csr(CSR_WEIGHT_NEW, {8'($urandom), w_new});
      write_csr(CSR_BLINK_PERIOD, pick_period());
      csr_done();
      req_gaps_on = gaps;
      repeat (n_items) send_sample(pick_sample());
   endtask

   // Main sequence
   initial begin : run_tests
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      req_chan.valid  <= 1'b0;
      req_chan.sample <= '0;
      cfg_thr_high   = THRESHOLD_HIGH_RST;
      cfg_thr_mid    = THRESHOLD_MID_RST;
      cfg_thr_low    = THRESHOLD_LOW_RST;
      cfg_weight_old = WEIGHT_OLD_RST;
      cfg_weight_new = WEIGHT_NEW_RST;
      cfg_period     = BLINK_PERIOD_RST;
      avg_value      = '0;
      blink_phase    = '0;
      blink_parity   = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      test_defaults();
      test_weight_extremes();
      test_zero_weights();
      test_threshold_order();
      test_blink_period();
      test_unused_index();
      test_backpressure();
      test_drain_pause();

      // rotate idling modes across phases, then finish with none
      for (int p = 0; p < 10; p++)
         test_random_phase(80, p % 4 != 2, p % 4 != 1);
      test_random_phase(80, 1'b0, 1'b0);

      settle_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d samples across directed and random settings, %0d results checked",
               samples_sent, results_checked);
      $display("%0d register writes, %0d blink wraps, %0d mismatches",
               csr_writes, wraps_seen, error_count);
      if (error_count == 0) begin
         $display("smoothed_adc_level_indicator_tb: done, clean");
      end else begin
         $display("smoothed_adc_level_indicator_tb: done, errors");
      end
      $finish;
   end

endmodule

### smoothed_adc_level_indicator.f
sv/sali_pkg.sv
sv/sali_req_if.sv
sv/sali_rsp_if.sv
sv/sali_core.sv
sv/smoothed_adc_level_indicator.sv
sv/sali_checker.sv
bench/smoothed_adc_level_indicator_tb.sv
